@@ hw/rtl/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants and types for the sprite scanline renderer.
// ----------------------------------------------------------------------------
package ssr_pkg;

  // Default sizes
  localparam int LINE_WIDTH_DEF = 160;
  localparam int TILE_BYTES_DEF = 4096;

  // Action codes
  localparam logic [1:0] ACT_TILE_WR = 2'd0;
  localparam logic [1:0] ACT_PIX_WR  = 2'd1;
  localparam logic [1:0] ACT_DRAW    = 2'd2;
  localparam logic [1:0] ACT_PIX_RD  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAL0    = 2'd0;
  localparam logic [1:0] CFG_PAL1    = 2'd1;
  localparam logic [1:0] CFG_TALL    = 2'd2;
  localparam logic [1:0] CFG_BG_ZERO = 2'd3;

  // Sprite geometry
  localparam logic [3:0] ROW_LAST_SHORT = 4'd7;
  localparam logic [3:0] ROW_LAST_TALL  = 4'd15;
  localparam int         COLS           = 8;
  localparam int         X_OFFSET       = 8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic tile_wr;  // store a tile byte
    logic pix_wr;   // store a line pixel
    logic pix_rd;   // load the output pixel register
    logic fetch;    // capture sprite and start the tile row read
    logic draw;     // merge the fetched row into the line
  } ssr_cmd_t;

endpackage

@@ hw/rtl/ssr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssr_ctrl
// Handshake control and sequencing of the sprite scanline renderer.
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       action_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssr_pkg::ssr_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   is_read;
  logic   accept;

  assign is_read    = (action_i == ssr_pkg::ACT_PIX_RD);
  // A read needs a free output slot; other actions go ahead regardless.
  assign in_ready_o = (state_q == ST_IDLE) && (!is_read || !out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.tile_wr = accept && (action_i == ssr_pkg::ACT_TILE_WR);
    cmd_o.pix_wr  = accept && (action_i == ssr_pkg::ACT_PIX_WR);
    cmd_o.fetch   = accept && (action_i == ssr_pkg::ACT_DRAW);
    cmd_o.pix_rd  = accept && is_read;
    cmd_o.draw    = (state_q == ST_DRAW);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.fetch) state_q <= ST_DRAW;
        end
        ST_DRAW: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cmd_o.pix_rd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ssr_datapath.sv @@
// ----------------------------------------------------------------------------
// ssr_datapath
// Tile memory, banked line buffer, palettes and sprite row merge.
// ----------------------------------------------------------------------------
module ssr_datapath #(
  parameter int LINE_WIDTH = ssr_pkg::LINE_WIDTH_DEF,
  parameter int TILE_BYTES = ssr_pkg::TILE_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssr_pkg::ssr_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic [11:0]       location_i,
  input  logic [7:0]        write_data_i,
  input  logic [7:0]        sprite_y_i,
  input  logic [7:0]        sprite_col_i,
  input  logic [7:0]        tile_number_i,
  input  logic              flip_x_i,
  input  logic              flip_y_i,
  input  logic              palette_select_i,
  input  logic              behind_background_i,
  input  logic [7:0]        scan_line_i,
  output logic [1:0]        pixel_value_o
);

  localparam int COLS       = ssr_pkg::COLS;
  localparam int AW         = $clog2(TILE_BYTES);
  localparam int TIW        = AW - 1;
  localparam int BANK_WORDS = TILE_BYTES / 2;
  localparam int BANK_DEPTH = (LINE_WIDTH + COLS - 1) / COLS;
  localparam int BIW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [9:0] POS_LO = 10'(ssr_pkg::X_OFFSET);
  localparam logic [9:0] POS_HI = 10'(LINE_WIDTH + ssr_pkg::X_OFFSET);

  // Configuration
  logic [7:0] pal0_q, pal1_q;
  logic       tall_q;
  logic [1:0] bg_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal0_q    <= '0;
      pal1_q    <= '0;
      tall_q    <= 1'b0;
      bg_zero_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ssr_pkg::CFG_PAL0:    pal0_q    <= cfg_wdata_i;
        ssr_pkg::CFG_PAL1:    pal1_q    <= cfg_wdata_i;
        ssr_pkg::CFG_TALL:    tall_q    <= cfg_wdata_i[0];
        ssr_pkg::CFG_BG_ZERO: bg_zero_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Tile memory: even and odd bytes in separate banks so a row's two
  // bytes come out in one read.
  logic [7:0]     tile_even_mem [BANK_WORDS];
  logic [7:0]     tile_odd_mem  [BANK_WORDS];
  logic [AW-1:0]  tile_wr_addr;
  logic [3:0]     row_raw, row_last, row;
  logic [7:0]     tile_eff;
  logic [12:0]    row_sum;
  logic [TIW-1:0] tile_rd_idx;
  logic [7:0]     b0_q, b1_q;

  assign tile_wr_addr = AW'(location_i);
  // Only the low four row bits matter; the +16 bias drops out.
  assign row_raw  = scan_line_i[3:0] - sprite_y_i[3:0];
  assign row_last = tall_q ? ssr_pkg::ROW_LAST_TALL : ssr_pkg::ROW_LAST_SHORT;
  assign row      = flip_y_i ? (row_last - row_raw) : row_raw;
  assign tile_eff = tall_q ? {tile_number_i[7:1], 1'b0} : tile_number_i;
  assign row_sum  = {2'b00, tile_eff, 3'b000} + {9'd0, row};
  assign tile_rd_idx = TIW'(row_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tile_wr) begin
      if (tile_wr_addr[0]) begin
        tile_odd_mem[tile_wr_addr[AW-1:1]] <= write_data_i;
      end else begin
        tile_even_mem[tile_wr_addr[AW-1:1]] <= write_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      b0_q <= tile_even_mem[tile_rd_idx];
      b1_q <= tile_odd_mem[tile_rd_idx];
    end
  end

  // Sprite attributes held for the merge cycle
  logic [7:0] sx_q;
  logic       flip_x_q, pal_sel_q, behind_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      sx_q      <= sprite_col_i;
      flip_x_q  <= flip_x_i;
      pal_sel_q <= palette_select_i;
      behind_q  <= behind_background_i;
    end
  end

  // Line buffer: eight banks by x mod 8, so a sprite row touches each
  // bank exactly once.
  logic [1:0]     line_mem [COLS][BANK_DEPTH];
  logic [2:0]     col      [COLS];
  logic [9:0]     xp       [COLS];
  logic [7:0]     pos      [COLS];
  logic [BIW-1:0] dr_idx   [COLS];
  logic [2:0]     tbit     [COLS];
  logic [1:0]     color    [COLS];
  logic [1:0]     shade    [COLS];
  logic [1:0]     cur      [COLS];
  logic           dr_we    [COLS];
  logic [7:0]     palette;

  assign palette = pal_sel_q ? pal1_q : pal0_q;

  always_comb begin
    for (int b = 0; b < COLS; b++) begin
      col[b]    = 3'(b) - sx_q[2:0];
      xp[b]     = {2'b00, sx_q} + {7'd0, col[b]};
      pos[b]    = 8'(xp[b] - POS_LO);
      dr_idx[b] = BIW'(pos[b] >> 3);
      tbit[b]   = flip_x_q ? col[b] : (3'd7 - col[b]);
      color[b]  = {b1_q[tbit[b]], b0_q[tbit[b]]};
      shade[b]  = palette[{color[b], 1'b0} +: 2];
      cur[b]    = line_mem[b][dr_idx[b]];
      dr_we[b]  = cmd_i.draw && (xp[b] >= POS_LO) && (xp[b] < POS_HI) &&
                  (color[b] != 2'd0) && (!behind_q || (cur[b] == bg_zero_q));
    end
  end

  logic           loc_ok;
  logic [2:0]     loc_bank;
  logic [BIW-1:0] loc_idx;

  assign loc_ok   = (location_i < 12'(LINE_WIDTH));
  assign loc_bank = location_i[2:0];
  assign loc_idx  = BIW'(location_i >> 3);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_wr && loc_ok) begin
      line_mem[loc_bank][loc_idx] <= write_data_i[1:0];
    end
    for (int b = 0; b < COLS; b++) begin
      if (dr_we[b]) begin
        line_mem[b][dr_idx[b]] <= shade[b];
      end
    end
  end

  // Output pixel register
  logic [1:0] pixel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_rd) begin
      pixel_q <= loc_ok ? line_mem[loc_bank][loc_idx] : 2'd0;
    end
  end

  assign pixel_value_o = pixel_q;

endmodule

@@ hw/rtl/sprite_scanline_renderer_unit.sv @@
// ----------------------------------------------------------------------------
// sprite_scanline_renderer_unit
// Object line renderer: tile memory plus one scanline of 2-bit pixels.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one action. Tile byte writes,
// line pixel writes and line pixel reads leave the controller idle: the block
// is ready again in the next cycle (for a further read once the output slot is
// free). A draw is split: the accepting cycle forms the tile row address and
// issues the synchronous tile memory read; in the following cycle, with ready
// low, all eight sprite columns merge into the line buffer at once. The
// tile memory is split into even and odd byte banks so both bytes of a row
// come out of one read, and the line buffer is split into eight banks by
// x mod 8 so one sprite row lands in each bank once. A read places its pixel
// in an output register; the block keeps accepting writes and draws while
// that result waits, and holds a further read until the slot is free.
// TILE_BYTES must be a power of two; tile addresses wrap modulo its size.
// Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module sprite_scanline_renderer_unit #(
  parameter int LINE_WIDTH = ssr_pkg::LINE_WIDTH_DEF,
  parameter int TILE_BYTES = ssr_pkg::TILE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [11:0] location_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  sprite_y_i,
  input  logic [7:0]  sprite_col_i,
  input  logic [7:0]  tile_number_i,
  input  logic        flip_x_i,
  input  logic        flip_y_i,
  input  logic        palette_select_i,
  input  logic        behind_background_i,
  input  logic [7:0]  scan_line_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  pixel_value_o
);

  ssr_pkg::ssr_cmd_t cmd;

  // Sequence actions and own the output valid flag.
  ssr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold memories, configuration and the pixel merge.
  ssr_datapath #(
    .LINE_WIDTH (LINE_WIDTH),
    .TILE_BYTES (TILE_BYTES)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .location_i          (location_i),
    .write_data_i        (write_data_i),
    .sprite_y_i          (sprite_y_i),
    .sprite_col_i        (sprite_col_i),
    .tile_number_i       (tile_number_i),
    .flip_x_i            (flip_x_i),
    .flip_y_i            (flip_y_i),
    .palette_select_i    (palette_select_i),
    .behind_background_i (behind_background_i),
    .scan_line_i         (scan_line_i),
    .pixel_value_o       (pixel_value_o)
  );

endmodule

@@ sim/tb_sprite_scanline_renderer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_sprite_scanline_renderer_unit
// Self-checking bench for the sprite scanline renderer. A tracker class keeps
// its own tile memory, scanline and settings, predicts every pixel read and
// compares it with the block's output. The stimulus is a short directed part
// followed by random sprite sequences and other actions under several register
// settings, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_scanline_renderer_unit;

  localparam int LINE_W     = ssr_pkg::LINE_WIDTH_DEF;
  localparam int TILE_B     = ssr_pkg::TILE_BYTES_DEF;
  localparam int COLS       = ssr_pkg::COLS;
  localparam int X_OFFSET   = ssr_pkg::X_OFFSET;
  localparam int TIMEOUT_NS = 10_000_000;

  // One input transaction, field by field as the ports carry it
  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] location;
    logic [7:0]  write_data;
    logic [7:0]  sprite_y;
    logic [7:0]  sprite_col;
    logic [7:0]  tile_number;
    logic        flip_x;
    logic        flip_y;
    logic        palette_select;
    logic        behind_background;
    logic [7:0]  scan_line;
  } pix_item_t;

  // Shadow of the tile memory and the scanline; predicts each pixel read
  class line_pixel_tracker;
    logic [7:0] tile_mem [TILE_B];
    logic [1:0] line_buf [LINE_W];
    logic [7:0] pal_zero = 8'h00;
    logic [7:0] pal_one  = 8'h00;
    logic       tall     = 1'b0;
    logic [1:0] bg_zero  = 2'd0;
    logic [1:0] pending_pixels [$];
    int         errors   = 0;

    // Byte address of the first byte of the tile row that a sprite draws
    static function logic [11:0] row_base(pix_item_t it, logic tall_mode);
      logic [7:0] tile;
      logic [7:0] row;
      tile = it.tile_number;
      if (tall_mode) tile[0] = 1'b0;
      row = it.scan_line - it.sprite_y + 8'd16;
      if (it.flip_y) begin
        row = (tall_mode ? {4'd0, ssr_pkg::ROW_LAST_TALL}
                         : {4'd0, ssr_pkg::ROW_LAST_SHORT}) - row;
      end
      return {tile, 4'd0} + {7'd0, row[3:0], 1'b0};
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        ssr_pkg::CFG_PAL0: pal_zero = val;
        ssr_pkg::CFG_PAL1: pal_one  = val;
        ssr_pkg::CFG_TALL: tall     = val[0];
        default:           bg_zero  = val[1:0];
      endcase
    endfunction

    function void note_action(pix_item_t it);
      logic [7:0]  pal;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [11:0] base;
      logic [1:0]  color;
      int          c;
      int          pos;
      int          bit_i;
      case (it.action)
        ssr_pkg::ACT_TILE_WR: tile_mem[it.location] = it.write_data;
        ssr_pkg::ACT_PIX_WR: begin
          if (it.location < LINE_W) line_buf[it.location] = it.write_data[1:0];
        end
        ssr_pkg::ACT_DRAW: begin
          pal  = it.palette_select ? pal_one : pal_zero;
          base = row_base(it, tall);
          b0   = tile_mem[base];
          b1   = tile_mem[base + 12'd1];
          for (c = 0; c < COLS; c++) begin
            pos   = int'(it.sprite_col) - X_OFFSET + c;
            bit_i = it.flip_x ? c : COLS - 1 - c;
            if (pos >= 0 && pos < LINE_W) begin
              color = {b1[bit_i], b0[bit_i]};
              // color 0 is transparent; behind sprites only cover background zero
              if (color != 2'd0 && !(it.behind_background && line_buf[pos] != bg_zero)) begin
                line_buf[pos] = pal[2 * int'(color) +: 2];
              end
            end
          end
        end
        default: begin
          pending_pixels.push_back((it.location < LINE_W) ? line_buf[it.location] : 2'd0);
        end
      endcase
    endfunction

    function void check_pixel(logic [1:0] got);
      logic [1:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel_value with no read pending: expected none, actual %0d",
                 $time, got);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: pixel_value mismatch: expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_addr_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  pix_item_t  req_item;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] pixel_value_o;

  line_pixel_tracker tracker;

  // Stimulus side bookkeeping: which entries have been written so far, in
  // the order the transactions will be sent. Never read an unwritten entry.
  bit         tile_seen [TILE_B];
  bit         pix_seen  [LINE_W];
  logic       gen_tall = 1'b0;
  logic [1:0] gen_bg   = 2'd0;
  pix_item_t  stim_q [$];

  // Receiver stall pattern state
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  sprite_scanline_renderer_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_addr_i          (cfg_addr_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (req_item.action),
    .location_i          (req_item.location),
    .write_data_i        (req_item.write_data),
    .sprite_y_i          (req_item.sprite_y),
    .sprite_col_i        (req_item.sprite_col),
    .tile_number_i       (req_item.tile_number),
    .flip_x_i            (req_item.flip_x),
    .flip_y_i            (req_item.flip_y),
    .palette_select_i    (req_item.palette_select),
    .behind_background_i (req_item.behind_background),
    .scan_line_i         (req_item.scan_line),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pixel_value_o       (pixel_value_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watch both channels. Values read here are the ones from before the edge,
  // so a transaction is seen exactly when valid and ready were both high.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) tracker.note_action(req_item);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_pixel(pixel_value_o);
  end

  // Receiver: switch at random between stall modes, from always ready to mostly
  // stalled, plus a fixed periodic pattern.
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((rx_tick % 5) < 2);
    endcase
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic pix_item_t rand_item();
    pix_item_t it;
    it.action            = 2'($urandom);
    it.location          = 12'($urandom);
    it.write_data        = 8'($urandom);
    it.sprite_y          = 8'($urandom);
    it.sprite_col        = 8'($urandom);
    it.tile_number       = 8'($urandom);
    it.flip_x            = 1'($urandom);
    it.flip_y            = 1'($urandom);
    it.palette_select    = 1'($urandom);
    it.behind_background = 1'($urandom);
    it.scan_line         = 8'($urandom);
    return it;
  endfunction

  function automatic pix_item_t plain_item(logic [1:0] act, logic [11:0] loc, logic [7:0] data);
    pix_item_t it;
    it            = '0;
    it.action     = act;
    it.location   = loc;
    it.write_data = data;
    return it;
  endfunction

  function automatic pix_item_t sprite_item(logic [7:0] sy, logic [7:0] sx, logic [7:0] tile,
                                            logic fx, logic fy, logic ps, logic bh,
                                            logic [7:0] line);
    pix_item_t it;
    it                   = '0;
    it.action            = ssr_pkg::ACT_DRAW;
    it.sprite_y          = sy;
    it.sprite_col        = sx;
    it.tile_number       = tile;
    it.flip_x            = fx;
    it.flip_y            = fy;
    it.palette_select    = ps;
    it.behind_background = bh;
    it.scan_line         = line;
    return it;
  endfunction

  // Mostly sprites that cover the line at a random row, often on a small pool of
  // tiles so tile data gets reused; the rest have fully random attributes.
  function automatic pix_item_t make_sprite();
    pix_item_t  it;
    logic [7:0] row;
    it        = rand_item();
    it.action = ssr_pkg::ACT_DRAW;
    if ($urandom_range(0, 4) != 0) begin
      row         = 8'($urandom_range(0, gen_tall ? 15 : 7));
      it.sprite_y = it.scan_line + 8'd16 - row;
      if ($urandom_range(0, 3) != 0) it.sprite_col = 8'($urandom_range(0, LINE_W + 7));
      if ($urandom_range(0, 1) != 0) begin
        it.tile_number = {($urandom_range(0, 1) != 0) ? 6'h3F : 6'h00,
                          2'($urandom_range(0, 3))};
      end
    end
    return it;
  endfunction

  // Queue a transaction, preceded by whatever writes it needs so that it
  // never touches an entry that was never written.
  task automatic push_item(pix_item_t it);
    pix_item_t   pre;
    logic [11:0] addr;
    int          k;
    int          c;
    int          pos;
    if (it.action == ssr_pkg::ACT_DRAW) begin
      for (k = 0; k < 2; k++) begin
        addr = line_pixel_tracker::row_base(it, gen_tall) + 12'(k);
        if (!tile_seen[addr]) begin
          pre          = rand_item();
          pre.action   = ssr_pkg::ACT_TILE_WR;
          pre.location = addr;
          tile_seen[addr] = 1'b1;
          stim_q.push_back(pre);
        end
      end
      // fill the covered pixels first; lean toward the background-zero shade
      for (c = 0; c < COLS; c++) begin
        pos = int'(it.sprite_col) - X_OFFSET + c;
        if (pos >= 0 && pos < LINE_W && !pix_seen[pos]) begin
          pre          = rand_item();
          pre.action   = ssr_pkg::ACT_PIX_WR;
          pre.location = 12'(pos);
          if ($urandom_range(0, 1) != 0) pre.write_data[1:0] = gen_bg;
          pix_seen[pos] = 1'b1;
          stim_q.push_back(pre);
        end
      end
    end
    if (it.action == ssr_pkg::ACT_PIX_RD && it.location < LINE_W &&
        !pix_seen[it.location]) begin
      pre          = rand_item();
      pre.action   = ssr_pkg::ACT_PIX_WR;
      pre.location = it.location;
      pix_seen[it.location] = 1'b1;
      stim_q.push_back(pre);
    end
    if (it.action == ssr_pkg::ACT_TILE_WR) tile_seen[it.location] = 1'b1;
    if (it.action == ssr_pkg::ACT_PIX_WR && it.location < LINE_W) pix_seen[it.location] = 1'b1;
    stim_q.push_back(it);
  endtask

  // Send the queued transactions in bursts with random gaps between them.
  // Called and returning at a rising edge.
  task automatic drive_queue();
    pix_item_t it;
    int        burst;
    int        gap;
    burst = $urandom_range(1, 24);
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      in_valid_i <= 1'b1;
      req_item   <= it;
      // hold valid and payload until the transaction is taken
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      burst--;
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        gap   = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Wait until every read has come back, then give a draw in flight time
  // to finish its merge into the line.
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  // Change all four registers while the block is idle
  task automatic apply_settings(logic [7:0] p0, logic [7:0] p1, logic t, logic [1:0] bg);
    settle();
    write_reg(ssr_pkg::CFG_PAL0, p0);
    write_reg(ssr_pkg::CFG_PAL1, p1);
    write_reg(ssr_pkg::CFG_TALL, {7'd0, t});
    write_reg(ssr_pkg::CFG_BG_ZERO, {6'd0, bg});
    cfg_we_i <= 1'b0;
    gen_tall = t;
    gen_bg   = bg;
  endtask

  // Queue about n transactions, counting the writes that go in front too
  task automatic run_random(int n);
    pix_item_t it;
    pix_item_t rd;
    int        base;
    int        kind;
    int        nr;
    base = stim_q.size();
    while (stim_q.size() - base < n) begin
      kind = $urandom_range(0, 99);
      it   = rand_item();
      if (kind < 40) begin
        // sprite sequence: draw, then read back some of its columns
        it = make_sprite();
        push_item(it);
        nr = $urandom_range(0, 4);
        repeat (nr) begin
          rd          = rand_item();
          rd.action   = ssr_pkg::ACT_PIX_RD;
          rd.location = 12'(int'(it.sprite_col) - X_OFFSET + $urandom_range(0, COLS - 1));
          push_item(rd);
        end
      end else if (kind < 60) begin
        it.action = ssr_pkg::ACT_PIX_WR;
        if (kind < 57) it.location = 12'($urandom_range(0, LINE_W - 1));
        push_item(it);
      end else if (kind < 72) begin
        it.action = ssr_pkg::ACT_TILE_WR;
        push_item(it);
      end else begin
        it.action = ssr_pkg::ACT_PIX_RD;
        if (kind < 95) it.location = 12'($urandom_range(0, LINE_W - 1));
        push_item(it);
      end
    end
  endtask

  // Directed part, meant for palettes E4/1B, 8x8 sprites, background zero 0
  task automatic load_directed();
    // tile memory extremes and one known tile row (tile 1, row 0)
    push_item(plain_item(ssr_pkg::ACT_TILE_WR, 12'd0, 8'h00));
    push_item(plain_item(ssr_pkg::ACT_TILE_WR, 12'hFFF, 8'hFF));
    push_item(plain_item(ssr_pkg::ACT_TILE_WR, 12'd16, 8'hA5));
    push_item(plain_item(ssr_pkg::ACT_TILE_WR, 12'd17, 8'hC3));
    // line edges, and writes past the end of the line that must be dropped
    push_item(plain_item(ssr_pkg::ACT_PIX_WR, 12'd0, 8'hFF));
    push_item(plain_item(ssr_pkg::ACT_PIX_WR, 12'd159, 8'hFE));
    push_item(plain_item(ssr_pkg::ACT_PIX_WR, 12'd160, 8'h01));
    push_item(plain_item(ssr_pkg::ACT_PIX_WR, 12'hFFF, 8'h02));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd0, 8'h00));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd159, 8'h00));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd160, 8'h00));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'hFFF, 8'h00));
    // plain draw, mirrored in x with palette one, mirrored in y
    push_item(sprite_item(8'd16, 8'd8, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd7, 8'h00));
    push_item(sprite_item(8'd16, 8'd8, 8'd1, 1'b1, 1'b0, 1'b1, 1'b0, 8'd0));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd1, 8'h00));
    push_item(sprite_item(8'd16, 8'd8, 8'd1, 1'b0, 1'b1, 1'b0, 1'b0, 8'd7));
    // behind the background: only the pixel at background zero may change
    push_item(plain_item(ssr_pkg::ACT_PIX_WR, 12'd2, 8'h00));
    push_item(sprite_item(8'd16, 8'd8, 8'd1, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd2, 8'h00));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd3, 8'h00));
    // clipping at both ends of the line, and sprites fully off it
    push_item(sprite_item(8'd16, 8'd4, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(sprite_item(8'd16, 8'd167, 8'd1, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
    push_item(sprite_item(8'd16, 8'd0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(sprite_item(8'd16, 8'd255, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd159, 8'h00));
    // last row of the last tile, then a sprite that does not cover the line
    push_item(sprite_item(8'd9, 8'd80, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(sprite_item(8'd100, 8'd40, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd75, 8'h00));
  endtask

  initial begin
    tracker = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_item    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= ssr_pkg::CFG_PAL0;
    cfg_wdata_i <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_settings(8'hE4, 8'h1B, 1'b0, 2'd0);
    load_directed();
    run_random(100);
    drive_queue();

    // tall sprites: odd tile index loses its low bit, y flip mirrors over 15
    apply_settings(8'hFF, 8'h00, 1'b1, 2'd3);
    push_item(sprite_item(8'd54, 8'd100, 8'd3, 1'b0, 1'b1, 1'b0, 1'b1, 8'd50));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd95, 8'h00));
    push_item(sprite_item(8'd51, 8'd104, 8'd255, 1'b1, 1'b0, 1'b1, 1'b0, 8'd50));
    push_item(plain_item(ssr_pkg::ACT_PIX_RD, 12'd99, 8'h00));
    run_random(140);
    drive_queue();

    apply_settings(8'h00, 8'hFF, 1'b0, 2'd1);
    run_random(140);
    drive_queue();

    repeat (4) begin
      apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 2'($urandom));
      run_random(100);
      drive_queue();
    end

    // drain the last reads and let the final draw complete
    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
